FILE: sv/dda_pkg.sv
package dda_pkg;

   // Field widths
   localparam int COORD_BITS = 11;                    // logical endpoint coordinate
   localparam int FRAC_BITS  = 16;                    // fraction bits of position and increment
   localparam int OUT_BITS   = COORD_BITS + 1;        // screen coordinate, signed
   localparam int DELTA_BITS = COORD_BITS + 1;        // signed endpoint difference
   localparam int MAG_BITS   = COORD_BITS;            // |dx|, |dy|, step count
   localparam int QUO_BITS   = FRAC_BITS + 1;         // increment magnitude, at most 2^FRAC_BITS
   localparam int DIV_BITS   = MAG_BITS + FRAC_BITS + 1;
   localparam int STEP_BITS  = FRAC_BITS + 2;         // signed increment
   localparam int POS_BITS   = FRAC_BITS + OUT_BITS;  // signed position
   localparam int CNT_BITS   = $clog2(QUO_BITS);

   localparam int ORIGIN_BITS    = 10;
   localparam int COLOR_BITS     = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 10;

   // Opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_X    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_Y    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIXEL_COLOR = 2'd2;

   // Register reset values
   localparam logic [ORIGIN_BITS-1:0] ORIGIN_X_RESET    = 10'd290;
   localparam logic [ORIGIN_BITS-1:0] ORIGIN_Y_RESET    = 10'd275;
   localparam logic [COLOR_BITS-1:0]  PIXEL_COLOR_RESET = 4'd10;

   typedef struct packed {
      logic start;     // load a new line and emit its first pixel
      logic step;      // advance the active line by one pixel
      logic div_step;  // one quotient bit of both increment divisions
      logic fixup;     // apply the signs to the increments
   } cmd_type;

   typedef struct packed {
      logic zero_len;  // pending start item has coincident endpoints
      logic out_free;  // output register can take a pixel this cycle
   } status_type;

endpackage

FILE: sv/dda_ctrl.sv
module dda_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  dda_pkg::status_type  status,
   output dda_pkg::cmd_type     cmd
);
   import dda_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_SIGN   = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd          = '0;
      cmd.start    = accept && (req_op == OP_START);
      cmd.step     = accept && (req_op == OP_STEP);
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.fixup    = (state_ff == ST_SIGN);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (cmd.start && !status.zero_len) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(QUO_BITS - 1)) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: sv/dda_datapath.sv
module dda_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dda_pkg::cmd_type                       cmd,
   output dda_pkg::status_type                    status,
   input  logic signed [dda_pkg::COORD_BITS-1:0]  req_from_x,
   input  logic signed [dda_pkg::COORD_BITS-1:0]  req_from_y,
   input  logic signed [dda_pkg::COORD_BITS-1:0]  req_to_x,
   input  logic signed [dda_pkg::COORD_BITS-1:0]  req_to_y,
   input  logic                                   csr_we,
   input  logic [dda_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dda_pkg::CSR_DATA_BITS-1:0]      csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dda_pkg::OUT_BITS-1:0]    rsp_screen_x,
   output logic signed [dda_pkg::OUT_BITS-1:0]    rsp_screen_y,
   output logic [dda_pkg::COLOR_BITS-1:0]         rsp_color,
   output logic                                   rsp_last_pixel
);
   import dda_pkg::*;

   // One restoring-division step: shift in the next dividend bit, subtract if it fits.
   function automatic logic [MAG_BITS+QUO_BITS-1:0] div_iter(
      input logic [MAG_BITS-1:0] rem,
      input logic [QUO_BITS-1:0] qsh,
      input logic [MAG_BITS-1:0] div
   );
      logic [MAG_BITS:0]   t;
      logic                ge;
      logic [MAG_BITS-1:0] r;
      t  = {rem, qsh[QUO_BITS-1]};
      ge = (t >= {1'b0, div});
      r  = ge ? MAG_BITS'(t - {1'b0, div}) : t[MAG_BITS-1:0];
      return {r, qsh[QUO_BITS-2:0], ge};
   endfunction

   // Configuration
   logic [ORIGIN_BITS-1:0] origin_x_ff, origin_y_ff;
   logic [COLOR_BITS-1:0]  color_ff;

   // Setup
   logic signed [DELTA_BITS-1:0] dx, dy;
   logic [MAG_BITS-1:0]          ax, ay, n;
   logic [DIV_BITS-1:0]          dividend_x, dividend_y;

   // Divider
   logic [MAG_BITS-1:0] rem_x_ff, rem_x_in, rem_y_ff, rem_y_in, div_n_ff;
   logic [QUO_BITS-1:0] qsh_x_ff, qsh_x_in, qsh_y_ff, qsh_y_in;
   logic                neg_x_ff, neg_y_ff;

   // Line state
   logic [STEP_BITS-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [POS_BITS-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [MAG_BITS-1:0]  steps_rem_ff, steps_rem_in;
   logic                 active_ff, active_in;

   // Output
   logic                emit, last_in;
   logic [OUT_BITS-1:0] rx, ry;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [COLOR_BITS-1:0] rsp_color_ff;
   logic                rsp_last_ff;

   // Endpoint differences, step count and scaled dividends (n/2 added for rounding)
   always_comb begin
      dx = {req_to_x[COORD_BITS-1], req_to_x} - {req_from_x[COORD_BITS-1], req_from_x};
      dy = {req_to_y[COORD_BITS-1], req_to_y} - {req_from_y[COORD_BITS-1], req_from_y};
      ax = dx[DELTA_BITS-1] ? MAG_BITS'(-dx) : dx[MAG_BITS-1:0];
      ay = dy[DELTA_BITS-1] ? MAG_BITS'(-dy) : dy[MAG_BITS-1:0];
      n  = (ax > ay) ? ax : ay;
      dividend_x = {1'b0, ax, {FRAC_BITS{1'b0}}} + DIV_BITS'(n >> 1);
      dividend_y = {1'b0, ay, {FRAC_BITS{1'b0}}} + DIV_BITS'(n >> 1);
   end

   assign status.zero_len = (n == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Divider: quotient is below 2^QUO_BITS, so the upper dividend bits start as remainder
   always_comb begin
      rem_x_in = rem_x_ff;
      qsh_x_in = qsh_x_ff;
      rem_y_in = rem_y_ff;
      qsh_y_in = qsh_y_ff;
      if (cmd.start) begin
         rem_x_in = dividend_x[DIV_BITS-1:QUO_BITS];
         qsh_x_in = dividend_x[QUO_BITS-1:0];
         rem_y_in = dividend_y[DIV_BITS-1:QUO_BITS];
         qsh_y_in = dividend_y[QUO_BITS-1:0];
      end else if (cmd.div_step) begin
         {rem_x_in, qsh_x_in} = div_iter(rem_x_ff, qsh_x_ff, div_n_ff);
         {rem_y_in, qsh_y_in} = div_iter(rem_y_ff, qsh_y_ff, div_n_ff);
      end
   end

   // Increments
   always_comb begin
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      if (cmd.start) begin
         step_x_in = '0;
         step_y_in = '0;
      end else if (cmd.fixup) begin
         step_x_in = neg_x_ff ? STEP_BITS'(-{1'b0, qsh_x_ff}) : {1'b0, qsh_x_ff};
         step_y_in = neg_y_ff ? STEP_BITS'(-{1'b0, qsh_y_ff}) : {1'b0, qsh_y_ff};
      end
   end

   // Position is kept biased by one half, so rounding is a plain slice
   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      steps_rem_in = steps_rem_ff;
      active_in    = active_ff;
      last_in      = 1'b0;
      if (cmd.start) begin
         pos_x_in = {req_from_x[COORD_BITS-1], req_from_x, 1'b1, {(FRAC_BITS-1){1'b0}}};
         pos_y_in = {req_from_y[COORD_BITS-1], req_from_y, 1'b1, {(FRAC_BITS-1){1'b0}}};
         steps_rem_in = n;
         active_in    = (n != '0);
         last_in      = (n == '0);
      end else if (cmd.step && active_ff) begin
         pos_x_in = pos_x_ff + {{(POS_BITS-STEP_BITS){step_x_ff[STEP_BITS-1]}}, step_x_ff};
         pos_y_in = pos_y_ff + {{(POS_BITS-STEP_BITS){step_y_ff[STEP_BITS-1]}}, step_y_ff};
         steps_rem_in = steps_rem_ff - 1'b1;
         active_in    = (steps_rem_ff != MAG_BITS'(1));
         last_in      = (steps_rem_ff == MAG_BITS'(1));
      end
   end

   // Screen mapping, y flipped
   assign emit     = cmd.start || (cmd.step && active_ff);
   assign rx       = pos_x_in[POS_BITS-1:FRAC_BITS];
   assign ry       = pos_y_in[POS_BITS-1:FRAC_BITS];
   assign rsp_x_in = OUT_BITS'(origin_x_ff) + rx;
   assign rsp_y_in = OUT_BITS'(origin_y_ff) - ry;

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= ORIGIN_X_RESET;
         origin_y_ff  <= ORIGIN_Y_RESET;
         color_ff     <= PIXEL_COLOR_RESET;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ORIGIN_X:    origin_x_ff <= csr_data[ORIGIN_BITS-1:0];
               CSR_ORIGIN_Y:    origin_y_ff <= csr_data[ORIGIN_BITS-1:0];
               CSR_PIXEL_COLOR: color_ff    <= csr_data[COLOR_BITS-1:0];
               default: ;
            endcase
         end
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_x_ff     <= rem_x_in;
      qsh_x_ff     <= qsh_x_in;
      rem_y_ff     <= rem_y_in;
      qsh_y_ff     <= qsh_y_in;
      step_x_ff    <= step_x_in;
      step_y_ff    <= step_y_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      steps_rem_ff <= steps_rem_in;
      if (cmd.start) begin
         div_n_ff <= n;
         neg_x_ff <= dx[DELTA_BITS-1];
         neg_y_ff <= dy[DELTA_BITS-1];
      end
      if (emit) begin
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_screen_x   = rsp_x_ff;
   assign rsp_screen_y   = rsp_y_ff;
   assign rsp_color      = rsp_color_ff;
   assign rsp_last_pixel = rsp_last_ff;

endmodule

FILE: sv/dda_line_rasterizer.sv
// DDA line rasterizer. A start item (op 0) loads two logical endpoints and puts the first
// pixel in the output register at the next edge; for a line longer than one pixel it then
// runs a setup, during which req_ready is low: in the divide state a restoring divider
// produces one quotient bit of both the x and y increments per cycle, then the sign
// state applies the signs. A zero-length line needs no setup. Each step item (op 1)
// emits the next pixel, so pixels stream at one per cycle while rsp_ready stays high;
// a step with no active line is taken and yields nothing. Pixels are rounded to nearest,
// offset by origin_x/origin_y with y flipped, and the final endpoint has rsp_last_pixel
// set. After reset origin_x = 290, origin_y = 275 and pixel_color = 10; write the
// registers only while no transfer is pending.
module dda_line_rasterizer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_op,
   input  logic signed [dda_pkg::COORD_BITS-1:0]  req_from_x,
   input  logic signed [dda_pkg::COORD_BITS-1:0]  req_from_y,
   input  logic signed [dda_pkg::COORD_BITS-1:0]  req_to_x,
   input  logic signed [dda_pkg::COORD_BITS-1:0]  req_to_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dda_pkg::OUT_BITS-1:0]    rsp_screen_x,
   output logic signed [dda_pkg::OUT_BITS-1:0]    rsp_screen_y,
   output logic [dda_pkg::COLOR_BITS-1:0]         rsp_color,
   output logic                                   rsp_last_pixel,
   input  logic                                   csr_we,
   input  logic [dda_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dda_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import dda_pkg::*;

   cmd_type    cmd;
   status_type status;

   dda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   dda_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_from_x     (req_from_x),
      .req_from_y     (req_from_y),
      .req_to_x       (req_to_x),
      .req_to_y       (req_to_y),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .rsp_color      (rsp_color),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

FILE: sv/dda_checker.sv
module dda_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   req_op,
   input logic signed [dda_pkg::COORD_BITS-1:0]  req_from_x,
   input logic signed [dda_pkg::COORD_BITS-1:0]  req_from_y,
   input logic signed [dda_pkg::COORD_BITS-1:0]  req_to_x,
   input logic signed [dda_pkg::COORD_BITS-1:0]  req_to_y,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [dda_pkg::OUT_BITS-1:0]    rsp_screen_x,
   input logic signed [dda_pkg::OUT_BITS-1:0]    rsp_screen_y,
   input logic [dda_pkg::COLOR_BITS-1:0]         rsp_color,
   input logic                                   rsp_last_pixel
);
   import dda_pkg::*;

   logic start_xfer, point_line;

   assign start_xfer = req_valid && req_ready && (req_op == OP_START);
   assign point_line = (req_from_x == req_to_x) && (req_from_y == req_to_y);

   // Hold a stalled pixel
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x)
         && $stable(rsp_screen_y) && $stable(rsp_color) && $stable(rsp_last_pixel))
      else $error("stalled pixel changed");

   // A single-point line yields exactly its one, final pixel
   a_point_last: assert property (@(posedge clock) disable iff (reset)
      start_xfer && point_line |=> rsp_valid && rsp_last_pixel)
      else $error("single-point line pixel not flagged last");

   // A real line emits its first endpoint, not flagged last
   a_first_pixel: assert property (@(posedge clock) disable iff (reset)
      start_xfer && !point_line |=> rsp_valid && !rsp_last_pixel)
      else $error("first pixel of line missing or flagged last");

   // Setup blocks new items right after a real line is loaded
   a_setup_busy: assert property (@(posedge clock) disable iff (reset)
      start_xfer && !point_line |=> !req_ready)
      else $error("item accepted during line setup");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_op         (req_op),
   .req_from_x     (req_from_x),
   .req_from_y     (req_from_y),
   .req_to_x       (req_to_x),
   .req_to_y       (req_to_y),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_screen_x   (rsp_screen_x),
   .rsp_screen_y   (rsp_screen_y),
   .rsp_color      (rsp_color),
   .rsp_last_pixel (rsp_last_pixel)
);

FILE: tb/sv/dda_line_rasterizer_test.sv
`timescale 1ns / 100ps

module dda_line_rasterizer_test;
   import dda_pkg::*;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] sx;
      logic signed [OUT_BITS-1:0] sy;
      logic [COLOR_BITS-1:0]      color;
      logic                       last;
   } pixel_t;

   typedef enum logic {ROW_PREDICT, ROW_TYPED} row_kind_e;

   typedef struct {
      logic      op;
      int        fx, fy, tx, ty;
      row_kind_e kind;
      int        sx, sy, color;
      bit        last;
   } dir_row_t;

   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 30;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_op = OP_START;
   logic signed [COORD_BITS-1:0]  req_from_x = '0;
   logic signed [COORD_BITS-1:0]  req_from_y = '0;
   logic signed [COORD_BITS-1:0]  req_to_x = '0;
   logic signed [COORD_BITS-1:0]  req_to_y = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [OUT_BITS-1:0]    rsp_screen_x;
   logic signed [OUT_BITS-1:0]    rsp_screen_y;
   logic [COLOR_BITS-1:0]         rsp_color;
   logic                          rsp_last_pixel;
   logic                          csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = CSR_ORIGIN_X;
   logic [CSR_DATA_BITS-1:0]      csr_data = '0;

   dda_line_rasterizer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_from_x     (req_from_x),
      .req_from_y     (req_from_y),
      .req_to_x       (req_to_x),
      .req_to_y       (req_to_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .rsp_color      (rsp_color),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // line state mirrored from the block
   int     cfg_origin_x = ORIGIN_X_RESET;
   int     cfg_origin_y = ORIGIN_Y_RESET;
   int     cfg_color    = PIXEL_COLOR_RESET;
   longint pos_x, pos_y, inc_x, inc_y;
   int     steps_left;
   bit     line_on;

   pixel_t expected_pixels[$];
   int     pixels_made;
   int     error_count;
   int     send_idle_pct;
   int     recv_idle_pct;
   bit     hold_go;

   dir_row_t directed_rows [0:24] = '{
      '{OP_START, 0, 0, 0, 0, ROW_TYPED, 290, 275, 10, 1},
      '{OP_STEP, 1023, -1024, 1023, -1024, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_START, -1024, -1024, -1024, -1024, ROW_TYPED, -734, 1299, 10, 1},
      '{OP_START, 1023, 1023, 1023, 1023, ROW_TYPED, 1313, -748, 10, 1},
      '{OP_START, -1024, 1023, 1023, -1024, ROW_TYPED, -734, -748, 10, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, -1, -1, -1, -1, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_START, 0, 0, 3, 1, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_TYPED, 293, 274, 10, 1},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_START, 0, 0, 1, 5, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_START, 0, 0, 1, 2, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_START, 0, 0, -1, 2, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0},
      '{OP_STEP, 0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("dda_line_rasterizer_test: errors");
      $finish;
   end

   // nearest integer of a Q.16 position, ties upward
   function automatic longint round_q(longint p);
      return (p + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   // d / n in Q.16, ties away from zero
   function automatic longint inc_q(longint d, longint n);
      longint mag;
      longint q;
      mag = (d < 0 ? -d : d) <<< FRAC_BITS;
      q = (mag + n / 2) / n;
      return d < 0 ? -q : q;
   endfunction

   function automatic bit raster_step(input logic op,
                                      input logic signed [COORD_BITS-1:0] fx, fy, tx, ty,
                                      output pixel_t px);
      longint dx, dy, ax, ay, n;
      dx = longint'(tx) - longint'(fx);
      dy = longint'(ty) - longint'(fy);
      px = '0;
      if (op == OP_START) begin
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         n = ax > ay ? ax : ay;
         pos_x = longint'(fx) <<< FRAC_BITS;
         pos_y = longint'(fy) <<< FRAC_BITS;
         inc_x = n == 0 ? 0 : inc_q(dx, n);
         inc_y = n == 0 ? 0 : inc_q(dy, n);
         steps_left = int'(n);
         line_on = n != 0;
      end else begin
         if (!line_on)
            return 1'b0;
         pos_x += inc_x;
         pos_y += inc_y;
         steps_left--;
         line_on = steps_left != 0;
      end
      px.sx = OUT_BITS'(cfg_origin_x + round_q(pos_x));
      px.sy = OUT_BITS'(cfg_origin_y - round_q(pos_y));
      px.color = COLOR_BITS'(cfg_color);
      px.last = steps_left == 0;
      return 1'b1;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
      if (v > 1023)
         return 11'sd1023;
      if (v < -1024)
         return -11'sd1024;
      return COORD_BITS'(v);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // entered just after a posedge; valid stays high if no gap is drawn
   task automatic send_item(input logic op, input logic signed [COORD_BITS-1:0] fx, fy, tx, ty);
      pixel_t px;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_from_x <= fx;
      req_from_y <= fy;
      req_to_x   <= tx;
      req_to_y   <= ty;
      do @(posedge clock); while (!req_ready);
      if (raster_step(op, fx, fy, tx, ty, px)) begin
         expected_pixels.push_back(px);
         pixels_made++;
      end
   endtask

   // drop valid, drain all pixels, then let any setup finish
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_ORIGIN_X: cfg_origin_x = value & 'h3FF;
         CSR_ORIGIN_Y: cfg_origin_y = value & 'h3FF;
         default:      cfg_color    = value & 'hF;
      endcase
   endtask

   task automatic random_lines(input int goal);
      int kind, span, r, nsteps;
      logic signed [COORD_BITS-1:0] fx, fy, tx, ty;
      while (pixels_made < goal) begin
         kind = $urandom_range(99);
         fx = COORD_BITS'($urandom);
         fy = COORD_BITS'($urandom);
         if (kind < 10) begin
            // noise: any op with any fields
            send_item(1'($urandom), fx, fy, COORD_BITS'($urandom), COORD_BITS'($urandom));
         end else begin
            if (kind < 15) begin
               tx = COORD_BITS'($urandom);
               ty = COORD_BITS'($urandom);
            end else begin
               span = ($urandom_range(99) < 5) ? 300 : 20;
               tx = clamp_coord(longint'(fx) + $urandom_range(2 * span) - span);
               ty = clamp_coord(longint'(fy) + $urandom_range(2 * span) - span);
            end
            send_item(OP_START, fx, fy, tx, ty);
            nsteps = steps_left;
            r = $urandom_range(9);
            if (kind < 15)
               nsteps = $urandom_range(8);
            else if (r == 0)
               nsteps = $urandom_range(nsteps);
            else if (r == 1)
               nsteps += $urandom_range(3, 1);
            repeat (nsteps)
               send_item(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         COORD_BITS'($urandom), COORD_BITS'($urandom));
         end
      end
   endtask

   // receiver: random back-pressure plus one long hold on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= recv_idle_pct;
         end
      end
   end

   always @(posedge clock) begin
      pixel_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual x %0d y %0d", $time,
                     rsp_screen_x, rsp_screen_y);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("screen_x", want.sx, rsp_screen_x);
            check_field("screen_y", want.sy, rsp_screen_y);
            check_field("color", want.color, rsp_color);
            check_field("last_pixel", want.last, rsp_last_pixel);
         end
      end
   end

   initial begin
      pixel_t typed;
      send_idle_pct = 14;
      recv_idle_pct = 86;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, COORD_BITS'(directed_rows[i].fx),
                   COORD_BITS'(directed_rows[i].fy), COORD_BITS'(directed_rows[i].tx),
                   COORD_BITS'(directed_rows[i].ty));
         if (directed_rows[i].kind == ROW_TYPED) begin
            typed.sx    = OUT_BITS'(directed_rows[i].sx);
            typed.sy    = OUT_BITS'(directed_rows[i].sy);
            typed.color = COLOR_BITS'(directed_rows[i].color);
            typed.last  = directed_rows[i].last;
            expected_pixels[$] = typed;
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: begin
               csr_write(CSR_ORIGIN_X, 0);
               csr_write(CSR_ORIGIN_Y, 0);
               csr_write(CSR_PIXEL_COLOR, 0);
            end
            1: begin
               csr_write(CSR_ORIGIN_X, 1023);
               csr_write(CSR_ORIGIN_Y, 1023);
               csr_write(CSR_PIXEL_COLOR, 15);
            end
            default: begin
               csr_write(CSR_ORIGIN_X, $urandom_range(1023));
               csr_write(CSR_ORIGIN_Y, $urandom_range(1023));
               csr_write(CSR_PIXEL_COLOR, $urandom_range(15));
            end
         endcase
         send_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 86 : 0;
         recv_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 14 : 0;
         // stall the output while the sender keeps pushing
         if (ph == 4)
            hold_go = 1'b1;
         random_lines(pixels_made + 275);
      end

      drain();
      if (error_count == 0)
         $display("dda_line_rasterizer_test: clean");
      else
         $display("dda_line_rasterizer_test: errors");
      $finish;
   end

endmodule

FILE: sim.f
sv/dda_pkg.sv
sv/dda_ctrl.sv
sv/dda_datapath.sv
sv/dda_line_rasterizer.sv
sv/dda_checker.sv
tb/sv/dda_line_rasterizer_test.sv
